FILE: sv/lmbs_pkg.sv
// Shared types and constants for the LED matrix bit-plane scanner.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package lmbs_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 25;
  localparam int FIELDS = 4;

  localparam int ROW_W   = 5;
  localparam int FIELD_W = (FIELDS > 1) ? $clog2(FIELDS) : 1;
  localparam int DEPTH   = 2 * ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int EDGE_W  = 3;

  localparam logic [EDGE_W-1:0] EDGE_SAT   = EDGE_W'(5);
  localparam logic [EDGE_W-1:0] EDGE_POWER = EDGE_W'(4);
  localparam logic [ROW_W-1:0]  DRIVE_SPLIT = ROW_W'(15);
  localparam logic [ROW_W-1:0]  DRIVE_BASE  = ROW_W'(14);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_EDGE  = 2'd2
  } opcode_t;

  // One run of four shift bytes, handed from the controller to the output side.
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [FIELD_W-1:0] field;
    logic               off;
  } run_t;

endpackage

FILE: sv/lmbs_plane_ram.sv
// Bit-plane store: synchronous memory, one write and one read port,
// read data registered. Per-entry valid bits make unwritten rows read zero.
`timescale 1ns / 1ps

module lmbs_plane_ram
  import lmbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [COLS-1:0]   wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [COLS-1:0]   rd_data
);

  logic [COLS-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [COLS-1:0]  rd_word;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

FILE: sv/lmbs_scan_ctrl.sv
// Scan controller: decodes input transfers, keeps row, field, edge and
// sleep state, drives the plane store and issues runs. Uses lmbs_pkg.
`timescale 1ns / 1ps

module lmbs_scan_ctrl
  import lmbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        opcode,
  input  logic              plane_select,
  input  logic [ROW_W-1:0]  write_row,
  input  logic [COLS-1:0]   row_bits,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [COLS-1:0]   wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              issue,
  output run_t              issue_run
);

  logic [ROW_W-1:0]   row_cnt, row_cnt_next;
  logic [FIELD_W-1:0] field_cnt, field_cnt_next;
  logic [EDGE_W-1:0]  edge_cnt, edge_cnt_next, edge_inc;
  logic               sleeping, sleeping_next;

  assign wr_addr = plane_select ? ADDR_W'(ROWS) + ADDR_W'(write_row) : ADDR_W'(write_row);
  assign wr_data = row_bits;
  assign rd_addr = (field_cnt == '0) ? ADDR_W'(row_cnt)
                                     : ADDR_W'(ROWS) + ADDR_W'(row_cnt);
  assign edge_inc = (edge_cnt < EDGE_SAT) ? edge_cnt + EDGE_W'(1) : edge_cnt;

  always_comb begin
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    issue          = 1'b0;
    issue_run      = '0;
    row_cnt_next   = row_cnt;
    field_cnt_next = field_cnt;
    edge_cnt_next  = edge_cnt;
    sleeping_next  = sleeping;
    unique case (opcode)
      OP_WRITE: begin
        wr_en = accept && (write_row < ROW_W'(ROWS));
      end
      OP_TICK: begin
        if (!sleeping) begin
          rd_en           = accept;
          issue           = accept;
          issue_run.row   = row_cnt;
          issue_run.field = field_cnt;
          if (row_cnt == ROW_W'(ROWS - 1)) begin
            row_cnt_next   = '0;
            field_cnt_next = (field_cnt == FIELD_W'(FIELDS - 1)) ? '0
                                                                 : field_cnt + FIELD_W'(1);
          end else begin
            row_cnt_next = row_cnt + ROW_W'(1);
          end
        end
      end
      OP_EDGE: begin
        edge_cnt_next = edge_inc;
        if (sleeping) begin
          sleeping_next = 1'b0;
        end else if (edge_inc == EDGE_POWER) begin
          issue         = accept;
          issue_run.off = 1'b1;
          sleeping_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      field_cnt <= '0;
      edge_cnt  <= '0;
      sleeping  <= 1'b0;
    end else if (accept) begin
      row_cnt   <= row_cnt_next;
      field_cnt <= field_cnt_next;
      edge_cnt  <= edge_cnt_next;
      sleeping  <= sleeping_next;
    end
  end

endmodule

FILE: sv/lmbs_out_ser.sv
// Output side: one pending run aligned with the store read data, then a
// byte serializer that sends four bytes per run. Uses lmbs_pkg.
`timescale 1ns / 1ps

module lmbs_out_ser
  import lmbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            issue,
  input  run_t            issue_run,
  input  logic [COLS-1:0] rd_data,
  output logic            take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      shift_byte,
  output logic            latch_last,
  output logic [7:0]      row_drive,
  output logic [4:0]      scan_row,
  output logic [1:0]      scan_field,
  output logic            power_off
);

  logic            pend_valid;
  run_t            pend_run;
  logic            ser_valid;
  run_t            ser_run;
  logic [31:0]     ser_bits;
  logic [1:0]      cnt;
  logic            ser_done;
  logic            ser_free;
  logic            pend_move;
  logic [7:0]      drive;

  assign ser_done  = ser_valid && out_ready && (cnt == 2'd3);
  assign ser_free  = !ser_valid || ser_done;
  assign pend_move = pend_valid && ser_free;
  assign take      = !pend_valid || pend_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      ser_valid  <= 1'b0;
      cnt        <= '0;
    end else begin
      if (issue) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        ser_valid <= 1'b1;
        cnt       <= '0;
      end else if (ser_done) begin
        ser_valid <= 1'b0;
        cnt       <= '0;
      end else if (ser_valid && out_ready) begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_run <= issue_run;
    end
    if (pend_move) begin
      ser_run  <= pend_run;
      ser_bits <= pend_run.off ? '0 : 32'(rd_data);
    end
  end

  always_comb begin
    case (cnt)
      2'd0:    shift_byte = ser_bits[31:24];
      2'd1:    shift_byte = ser_bits[23:16];
      2'd2:    shift_byte = ser_bits[15:8];
      default: shift_byte = ser_bits[7:0];
    endcase
  end

  always_comb begin
    if (ser_run.row < DRIVE_SPLIT) begin
      drive = 8'(ser_run.row) + 8'd1;
    end else begin
      drive = {4'(ser_run.row - DRIVE_BASE), 4'b0000};
    end
  end

  assign out_valid  = ser_valid;
  assign latch_last = (cnt == 2'd3);
  assign row_drive  = (latch_last && !ser_run.off) ? drive : 8'd0;
  assign scan_row   = ser_run.row;
  assign scan_field = 2'(ser_run.field);
  assign power_off  = ser_run.off;

endmodule

FILE: sv/led_matrix_bitplane_scanner_core.sv
// LED matrix bit-plane scanner, top level. Uses lmbs_pkg, lmbs_scan_ctrl,
// lmbs_plane_ram and lmbs_out_ser.
// A tick or edge run waits in the pending register, then moves to the serializer.
// Throughput: one write per cycle while no run waits in the buffer; ticks are paced
// by the byte serializer, sending one shift byte per cycle while m_tready is high.
// Reset: synchronous; counters and sleep clear, all plane rows read zero.
`timescale 1ns / 1ps

module led_matrix_bitplane_scanner_core
  import lmbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // plane_select, write_row[4:0], row_bits[24:0], zero pad
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // shift_byte[7:0], row_drive[7:0], scan_row[4:0],
                                 // scan_field[1:0], zero pad
  output logic        m_tlast,
  output logic        m_tuser    // power_off
);

  logic              accept;
  logic              wr_en, rd_en, issue;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [COLS-1:0]   wr_data, rd_data;
  run_t              issue_run;
  logic [7:0]        shift_byte, row_drive;
  logic [4:0]        scan_row;
  logic [1:0]        scan_field;

  assign accept = s_tvalid && s_tready;

  lmbs_scan_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (s_tuser),
    .plane_select (s_tdata[0]),
    .write_row    (s_tdata[5:1]),
    .row_bits     (s_tdata[COLS+5:6]),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .issue        (issue),
    .issue_run    (issue_run)
  );

  lmbs_plane_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lmbs_out_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_run  (issue_run),
    .rd_data    (rd_data),
    .take       (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .shift_byte (shift_byte),
    .latch_last (m_tlast),
    .row_drive  (row_drive),
    .scan_row   (scan_row),
    .scan_field (scan_field),
    .power_off  (m_tuser)
  );

  assign m_tdata = {1'b0, scan_field, scan_row, row_drive, shift_byte};

endmodule
